>>> rtl/core/i2cmb_pkg.sv
// package for the i2c slave message buffer: sizes, codes, request and result types
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package i2cmb_pkg;

    // buffer sizes and the widths that follow from them
    localparam int RX_BYTES = 32;
    localparam int TX_BYTES = 32;
    localparam int RX_AW    = $clog2(RX_BYTES);
    localparam int RX_CW    = $clog2(RX_BYTES + 1);
    localparam int TX_AW    = $clog2(TX_BYTES);
    localparam int TX_CW    = $clog2(TX_BYTES + 1);
    localparam int MAX_MSGS = 16;
    localparam int MSG_CW   = $clog2(MAX_MSGS + 1);

    // request types
    localparam logic [1:0] REQ_EVENT  = 2'd0;
    localparam logic [1:0] REQ_PACK   = 2'd1;
    localparam logic [1:0] REQ_UNPACK = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_BUS  = 2'd0;
    localparam logic [1:0] KIND_PACK = 2'd1;
    localparam logic [1:0] KIND_MSG  = 2'd2;
    localparam logic [1:0] KIND_END  = 2'd3;

    // bus status codes after masking
    localparam logic [7:0] ST_MASK     = 8'hF8;
    localparam logic [7:0] ST_SLA_W    = 8'h60;
    localparam logic [7:0] ST_RX_DATA  = 8'h80;
    localparam logic [7:0] ST_STOP     = 8'hA0;
    localparam logic [7:0] ST_SLA_R    = 8'hA8;
    localparam logic [7:0] ST_TX_ACK   = 8'hB8;
    localparam logic [7:0] ST_TX_NACK  = 8'hC0;

    // length byte sent when nothing is ready
    localparam logic [7:0]  LEN_NONE  = 8'hFE;
    localparam logic [15:0] NAME_MASK = 16'hFFF0;

    // sticky error bits
    localparam logic [3:0] ERR_BAD_STATUS  = 4'b0001;
    localparam logic [3:0] ERR_EXTRA_WRITE = 4'b0010;
    localparam logic [3:0] ERR_EARLY_NACK  = 4'b0100;
    localparam logic [3:0] ERR_OVERRUN     = 4'b1000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  bus_status;
        logic [7:0]  rx_byte;
        logic [15:0] name_word;
        logic [15:0] value_word;
        logic        pack_last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  tx_byte;
        logic        tx_loaded;
        logic        ack_request;
        logic [3:0]  error_flags;
        logic        pack_accepted;
        logic [15:0] out_name;
        logic [15:0] out_value;
        logic [4:0]  msg_count;
        logic        new_data;
        logic        last;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic       latch;
        logic       unp_start;
        logic       ev_exec;
        logic       pk_wr;
        logic [1:0] pk_sel;
        logic       pk_fin;
        logic       unp_step;
        logic       unp_end;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic unp_done;
    } t_dp_sts;

endpackage

>>> rtl/core/i2c_slave_message_buffer.sv
// top level of the i2c slave message buffer: controller plus datapath
// depends on i2cmb_pkg, i2cmb_ctrl and i2cmb_datapath
`timescale 1ns / 1ps
//
// channel   direction  handshake               payload
// request   in         start high, busy low    i_item   (t_in_item)
// result    out        o_strobe, one cycle     o_result (t_out_item)
//
// a bus event request is accepted with the transmit store read,
//   then the state update runs; its result shows on the next cycle
// a pack request makes one transmit store write per byte of the pair
// an unpack request walks the receive store word by word: the receive
//   store gives one 16-bit word per cycle through its two read ports
// reset is synchronous and needs no clearing pass; results cannot be stalled
// and each strobe lasts exactly one cycle

module i2c_slave_message_buffer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  i2cmb_pkg::t_in_item  i_item,
    output logic                 o_strobe,
    output i2cmb_pkg::t_out_item o_result
);
    import i2cmb_pkg::*;

    // command and status between the two halves
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencing of each request
    i2cmb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_item.req_type),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (busy)
    );

    // buffer state, stores and the result register
    i2cmb_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

endmodule

>>> rtl/core/i2cmb_datapath.sv
// datapath of the i2c slave message buffer: buffer state, receive and transmit stores
// depends on i2cmb_pkg; driven by i2cmb_ctrl commands
`timescale 1ns / 1ps

module i2cmb_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  i2cmb_pkg::t_in_item  i_item,
    input  i2cmb_pkg::t_dp_cmd   i_cmd,
    output i2cmb_pkg::t_dp_sts   o_sts,
    output i2cmb_pkg::t_out_item o_result,
    output logic                 o_strobe
);
    import i2cmb_pkg::*;

    // stores
    logic [7:0] r_rx_mem [RX_BYTES];
    logic [7:0] r_tx_mem [TX_BYTES];

    // architectural state
    logic [RX_CW-1:0]  r_rx_count, n_rx_count;
    logic [TX_CW-1:0]  r_tx_len, n_tx_len;
    logic [TX_CW-1:0]  r_tx_index, n_tx_index;
    logic              r_tx_ready, n_tx_ready;
    logic              r_len_sent, n_len_sent;
    logic              r_pk_open, n_pk_open;
    logic              r_pending, n_pending;
    logic [3:0]        r_err, n_err;
    logic [15:0]       r_held_name, n_held_name;

    // unpack walk
    logic [RX_CW-1:0]  r_rd_idx, n_rd_idx;
    logic              r_rdv, n_rdv;
    logic [MSG_CW-1:0] r_msg_cnt, n_msg_cnt;
    logic [7:0]        r_rx_hi, r_rx_lo;

    // request and read data
    t_in_item          r_item;
    logic [7:0]        r_tx_rdata;
    t_out_item         r_out, n_out;
    logic              r_out_v, n_out_v;

    // helpers
    logic [7:0]        w_code_in, w_code;
    logic [TX_AW-1:0]  w_tx_rd_addr, w_tx_wr_addr;
    logic [TX_CW:0]    w_idx_p1;
    logic [TX_CW-1:0]  w_base;
    logic              w_fits;
    logic              w_tx_we;
    logic [7:0]        w_pk_byte;
    logic              w_rx_we;
    logic [RX_CW-1:0]  w_words;
    logic              w_issue;
    logic              w_rx_rd;
    logic [15:0]       w_word;
    logic [7:0]        v_txb;
    logic              v_ld, v_ack;

    assign w_code_in = i_item.bus_status & ST_MASK;
    assign w_code    = r_item.bus_status & ST_MASK;

    // transmit read address: the data phase of a read starts at entry zero
    always_comb begin
        if (w_code_in == ST_SLA_R) begin
            w_tx_rd_addr = '0;
        end else if (r_tx_index < TX_CW'(TX_BYTES)) begin
            w_tx_rd_addr = r_tx_index[TX_AW-1:0];
        end else begin
            w_tx_rd_addr = '0;
        end
    end

    assign w_idx_p1 = {1'b0, r_tx_index} + (TX_CW+1)'(1);

    // pack addressing
    assign w_base       = r_pk_open ? r_tx_len : '0;
    assign w_fits       = ({1'b0, w_base} + (TX_CW+1)'(4)) <= (TX_CW+1)'(TX_BYTES);
    assign w_tx_wr_addr = TX_AW'(w_base + TX_CW'(i_cmd.pk_sel));
    assign w_tx_we      = i_cmd.pk_wr && !r_tx_ready && w_fits;

    always_comb begin
        case (i_cmd.pk_sel)
            2'd0:    w_pk_byte = r_item.name_word[15:8];
            2'd1:    w_pk_byte = r_item.name_word[7:0];
            2'd2:    w_pk_byte = r_item.value_word[15:8];
            default: w_pk_byte = r_item.value_word[7:0];
        endcase
    end

    // receive write and word reads
    assign w_rx_we = i_cmd.ev_exec && (w_code == ST_RX_DATA)
                     && (r_rx_count < RX_CW'(RX_BYTES));
    assign w_words = r_rx_count >> 1;
    assign w_issue = r_rd_idx < w_words;
    assign w_rx_rd = i_cmd.unp_step && w_issue;
    assign w_word  = {r_rx_hi, r_rx_lo};

    assign o_sts.unp_done = !w_issue && !r_rdv;

    always_comb begin
        n_rx_count  = r_rx_count;
        n_tx_len    = r_tx_len;
        n_tx_index  = r_tx_index;
        n_tx_ready  = r_tx_ready;
        n_len_sent  = r_len_sent;
        n_pk_open   = r_pk_open;
        n_pending   = r_pending;
        n_err       = r_err;
        n_held_name = r_held_name;
        n_rd_idx    = r_rd_idx;
        n_rdv       = r_rdv;
        n_msg_cnt   = r_msg_cnt;
        n_out       = r_out;
        n_out_v     = 1'b0;
        v_txb       = 8'h00;
        v_ld        = 1'b0;
        v_ack       = 1'b0;

        if (i_cmd.unp_start) begin
            n_pending = 1'b0;
            n_rd_idx  = '0;
            n_rdv     = 1'b0;
            n_msg_cnt = '0;
        end

        if (i_cmd.ev_exec) begin
            case (w_code)
                ST_SLA_W: begin
                    v_ack = 1'b1;
                end
                ST_RX_DATA: begin
                    if (r_rx_count < RX_CW'(RX_BYTES)) begin
                        n_rx_count = r_rx_count + RX_CW'(1);
                    end else begin
                        n_err = r_err | ERR_OVERRUN;
                    end
                    v_ack = 1'b1;
                end
                ST_STOP: begin
                    n_pending = 1'b1;
                end
                ST_SLA_R: begin
                    v_ld = 1'b1;
                    if (!r_len_sent) begin
                        v_txb = r_tx_ready ? 8'(r_tx_len) : LEN_NONE;
                    end else begin
                        n_tx_index = TX_CW'(1);
                        v_txb      = r_tx_rdata;
                        v_ack      = 1'b1;
                    end
                end
                ST_TX_ACK: begin
                    if (w_idx_p1 < {1'b0, r_tx_len}) begin
                        v_txb      = r_tx_rdata;
                        n_tx_index = w_idx_p1[TX_CW-1:0];
                        v_ld       = 1'b1;
                        v_ack      = 1'b1;
                    end else if (w_idx_p1 == {1'b0, r_tx_len}) begin
                        v_txb      = r_tx_rdata;
                        n_tx_index = w_idx_p1[TX_CW-1:0];
                        v_ld       = 1'b1;
                    end else begin
                        n_err = r_err | ERR_EXTRA_WRITE;
                    end
                end
                ST_TX_NACK: begin
                    if (!r_len_sent) begin
                        n_len_sent = 1'b1;
                        v_ack      = 1'b1;
                    end else if (r_tx_index == r_tx_len) begin
                        n_len_sent = 1'b0;
                        n_tx_ready = 1'b0;
                        v_ack      = 1'b1;
                    end else begin
                        n_err = r_err | ERR_EARLY_NACK;
                    end
                end
                default: begin
                    // bus error and unknown codes
                    n_err      = r_err | ERR_BAD_STATUS;
                    n_tx_ready = 1'b0;
                    n_len_sent = 1'b0;
                    v_ld       = 1'b1;
                    v_ack      = 1'b1;
                end
            endcase
            n_out             = '0;
            n_out.result_kind = KIND_BUS;
            n_out.tx_byte     = v_txb;
            n_out.tx_loaded   = v_ld;
            n_out.ack_request = v_ack;
            n_out.error_flags = n_err;
            n_out.new_data    = n_pending;
            n_out.last        = 1'b1;
            n_out_v           = 1'b1;
        end

        if (i_cmd.pk_fin) begin
            n_out = '0;
            if (!r_tx_ready) begin
                if (w_fits) begin
                    n_tx_len            = w_base + TX_CW'(4);
                    n_out.pack_accepted = 1'b1;
                end else begin
                    n_tx_len = w_base;
                    n_err    = r_err | ERR_OVERRUN;
                end
                n_pk_open = !r_item.pack_last;
                if (r_item.pack_last) begin
                    n_tx_ready = 1'b1;
                end
            end
            n_out.result_kind = KIND_PACK;
            n_out.error_flags = n_err;
            n_out.new_data    = n_pending;
            n_out.last        = 1'b1;
            n_out_v           = 1'b1;
        end

        if (i_cmd.unp_step) begin
            n_rdv = w_issue;
            if (w_issue) begin
                n_rd_idx = r_rd_idx + RX_CW'(1);
            end
            if (r_rdv) begin
                if ((w_word & NAME_MASK) == NAME_MASK) begin
                    n_held_name = w_word;
                end else if (r_msg_cnt < MSG_CW'(MAX_MSGS)) begin
                    n_msg_cnt         = r_msg_cnt + MSG_CW'(1);
                    n_out             = '0;
                    n_out.result_kind = KIND_MSG;
                    n_out.error_flags = r_err;
                    n_out.out_name    = r_held_name;
                    n_out.out_value   = w_word;
                    n_out.new_data    = r_pending;
                    n_out_v           = 1'b1;
                end else begin
                    n_err = r_err | ERR_OVERRUN;
                end
            end
        end

        if (i_cmd.unp_end) begin
            n_rx_count        = '0;
            n_out             = '0;
            n_out.result_kind = KIND_END;
            n_out.error_flags = r_err;
            n_out.msg_count   = 5'(r_msg_cnt);
            n_out.new_data    = r_pending;
            n_out.last        = 1'b1;
            n_out_v           = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_count  <= '0;
            r_tx_len    <= '0;
            r_tx_index  <= '0;
            r_tx_ready  <= 1'b0;
            r_len_sent  <= 1'b0;
            r_pk_open   <= 1'b0;
            r_pending   <= 1'b0;
            r_err       <= '0;
            r_held_name <= '0;
            r_rd_idx    <= '0;
            r_rdv       <= 1'b0;
            r_msg_cnt   <= '0;
            r_out_v     <= 1'b0;
        end else begin
            r_rx_count  <= n_rx_count;
            r_tx_len    <= n_tx_len;
            r_tx_index  <= n_tx_index;
            r_tx_ready  <= n_tx_ready;
            r_len_sent  <= n_len_sent;
            r_pk_open   <= n_pk_open;
            r_pending   <= n_pending;
            r_err       <= n_err;
            r_held_name <= n_held_name;
            r_rd_idx    <= n_rd_idx;
            r_rdv       <= n_rdv;
            r_msg_cnt   <= n_msg_cnt;
            r_out_v     <= n_out_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
    end

    // transmit store
    always_ff @(posedge i_clk) begin
        if (w_tx_we) begin
            r_tx_mem[w_tx_wr_addr] <= w_pk_byte;
        end
        if (i_cmd.latch) begin
            r_tx_rdata <= r_tx_mem[w_tx_rd_addr];
        end
    end

    // receive store, two bytes of one word per read
    always_ff @(posedge i_clk) begin
        if (w_rx_we) begin
            r_rx_mem[r_rx_count[RX_AW-1:0]] <= r_item.rx_byte;
        end
        if (w_rx_rd) begin
            r_rx_hi <= r_rx_mem[RX_AW'({r_rd_idx, 1'b0})];
            r_rx_lo <= r_rx_mem[RX_AW'({r_rd_idx, 1'b1})];
        end
    end

    assign o_result = r_out;
    assign o_strobe = r_out_v;

endmodule

>>> rtl/core/i2cmb_ctrl.sv
// controller of the i2c slave message buffer: request sequencing
// depends on i2cmb_pkg; drives i2cmb_datapath
`timescale 1ns / 1ps

module i2cmb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_req_type,
    input  i2cmb_pkg::t_dp_sts i_sts,
    output i2cmb_pkg::t_dp_cmd o_cmd,
    output logic               o_busy
);
    import i2cmb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVENT,
        S_PACK,
        S_UNPACK
    } t_state;

    t_state     r_state;
    logic [1:0] r_pk_cnt;
    logic       w_accept;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.latch     = w_accept;
        o_cmd.unp_start = w_accept && (i_req_type == REQ_UNPACK);
        case (r_state)
            S_EVENT: begin
                o_cmd.ev_exec = 1'b1;
            end
            S_PACK: begin
                o_cmd.pk_wr  = 1'b1;
                o_cmd.pk_sel = r_pk_cnt;
                o_cmd.pk_fin = (r_pk_cnt == 2'd3);
            end
            S_UNPACK: begin
                o_cmd.unp_end  = i_sts.unp_done;
                o_cmd.unp_step = !i_sts.unp_done;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pk_cnt <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_pk_cnt <= '0;
                    if (w_accept) begin
                        case (i_req_type)
                            REQ_EVENT:  r_state <= S_EVENT;
                            REQ_PACK:   r_state <= S_PACK;
                            REQ_UNPACK: r_state <= S_UNPACK;
                            default:    r_state <= S_IDLE;
                        endcase
                    end
                end
                S_EVENT: begin
                    r_state <= S_IDLE;
                end
                S_PACK: begin
                    r_pk_cnt <= r_pk_cnt + 2'd1;
                    if (r_pk_cnt == 2'd3) begin
                        r_state <= S_IDLE;
                    end
                end
                S_UNPACK: begin
                    if (i_sts.unp_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
